/* sv/bce_pkg.sv */
// Shared types, constants and arithmetic helpers for the biquad cascade equalizer.
package bce_pkg;

   // Cascade geometry.
   localparam int BANDS      = 5;
   localparam int TERMS      = 5;
   localparam int NUM_COEF   = BANDS * TERMS;
   localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int COEF_AW    = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;

   // Field and datapath widths.
   localparam int MODE_W     = 2;
   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 5;
   localparam int COEF_W     = 24;
   localparam int DATA_W     = 32;
   localparam int COEF_FRAC  = 20;
   localparam int SAMPLE_SH  = 8;
   localparam int PROD_W     = DATA_W + COEF_W;
   localparam int ACC_W      = 60;
   localparam int RND_W      = ACC_W - COEF_FRAC;
   localparam int TERM_W     = 3;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // Coefficient terms within one band.
   localparam logic [TERM_W-1:0] TERM_A0 = 3'd0;
   localparam logic [TERM_W-1:0] TERM_A1 = 3'd1;
   localparam logic [TERM_W-1:0] TERM_A2 = 3'd2;
   localparam logic [TERM_W-1:0] TERM_B1 = 3'd3;
   localparam logic [TERM_W-1:0] TERM_B2 = 3'd4;

   // Accumulator operations.
   localparam logic [2:0] ACC_HOLD    = 3'd0;
   localparam logic [2:0] ACC_LOAD_Z1 = 3'd1;
   localparam logic [2:0] ACC_LOAD_Z2 = 3'd2;
   localparam logic [2:0] ACC_CLEAR   = 3'd3;
   localparam logic [2:0] ACC_ADD     = 3'd4;
   localparam logic [2:0] ACC_SUB     = 3'd5;

   // Coefficient value 1.0 in Q3.20.
   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

   // Command bundle from the controller to the datapath.
   typedef struct packed {
      logic               load_sample;
      logic               write_coef;
      logic               clear_delay;
      logic [BAND_W-1:0]  band;
      logic [TERM_W-1:0]  term;
      logic               mul_en;
      logic               mul_use_y;
      logic [2:0]         acc_op;
      logic               take_y;
      logic               take_z1;
      logic               take_z2;
      logic               next_x;
      logic               emit;
   } bce_cmd_type;

   // Rounded and saturated Q8.23 value.
   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] value;
   } bce_rnd_type;

   // Round half up from 43 fractional bits to 23 and saturate to 32 bits.
   function automatic bce_rnd_type bce_round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sum;
      logic signed [RND_W-1:0] r;
      logic                    fits;
      bce_rnd_type             res;
      sum  = acc + ACC_W'(1 << (COEF_FRAC - 1));
      r    = sum[ACC_W-1:COEF_FRAC];
      fits = (&r[RND_W-1:DATA_W-1]) || !(|r[RND_W-1:DATA_W-1]);
      res.sat = !fits;
      if (fits) begin
         res.value = r[DATA_W-1:0];
      end else if (r[RND_W-1]) begin
         res.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res.value = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

/* sv/bce_ifs.sv */
// Valid/ready channel interfaces for the equalizer request and response words.
interface bce_req_if
   import bce_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [INDEX_W-1:0]         coef_index;
   logic signed [COEF_W-1:0]   coef_value;

   modport source (output valid, mode, sample_in, coef_index, coef_value, input ready);
   modport sink   (input valid, mode, sample_in, coef_index, coef_value, output ready);
endinterface

interface bce_rsp_if
   import bce_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       clipped;

   modport source (output valid, sample_out, clipped, input ready);
   modport sink   (input valid, sample_out, clipped, output ready);
endinterface

/* sv/bce_datapath.sv */
// Datapath: coefficient table, delay registers, shared multiplier and accumulator.
module bce_datapath
   import bce_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  bce_cmd_type                cmd,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic [INDEX_W-1:0]         coef_index,
   input  logic signed [COEF_W-1:0]   coef_value,
   output logic signed [SAMPLE_W-1:0] sample_out,
   output logic                       clipped
);

   logic signed [COEF_W-1:0]   coef_ff [NUM_COEF];
   logic signed [DATA_W-1:0]   z1_ff [BANDS];
   logic signed [DATA_W-1:0]   z2_ff [BANDS];
   logic signed [DATA_W-1:0]   x_ff, x_in;
   logic signed [DATA_W-1:0]   y_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       flag_ff, flag_in;
   logic signed [SAMPLE_W-1:0] out_ff, out_in;
   logic                       clip_ff, clip_in;
   logic [COEF_AW-1:0]         coef_addr;
   logic signed [DATA_W-1:0]   mul_a;
   logic signed [COEF_W-1:0]   mul_b;
   bce_rnd_type                rnd;
   logic signed [DATA_W:0]     x_rounded;
   logic signed [DATA_W-SAMPLE_SH:0] y_wide;
   logic                       clamp_hi, clamp_lo;

   // Operand selection for the shared multiplier.
   assign coef_addr = COEF_AW'(cmd.band * TERMS) + COEF_AW'(cmd.term);
   assign mul_a     = cmd.mul_use_y ? y_ff : x_ff;
   assign mul_b     = coef_ff[coef_addr];
   assign prod_in   = mul_a * mul_b;

   // One rounding and saturation unit serves every section output.
   assign rnd = bce_round_sat(acc_ff);

   // Accumulator at 43 fractional bits.
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD_Z1: acc_in = {{(ACC_W-DATA_W-COEF_FRAC){z1_ff[cmd.band][DATA_W-1]}},
                                z1_ff[cmd.band], {COEF_FRAC{1'b0}}};
         ACC_LOAD_Z2: acc_in = {{(ACC_W-DATA_W-COEF_FRAC){z2_ff[cmd.band][DATA_W-1]}},
                                z2_ff[cmd.band], {COEF_FRAC{1'b0}}};
         ACC_CLEAR:   acc_in = '0;
         ACC_ADD:     acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_SUB:     acc_in = acc_ff - ACC_W'(prod_ff);
         default:     acc_in = acc_ff;
      endcase
   end

   // Sample register: widened input at start, previous section output between bands.
   always_comb begin
      x_in = x_ff;
      if (cmd.load_sample) begin
         x_in = {{(DATA_W-SAMPLE_W-SAMPLE_SH){sample_in[SAMPLE_W-1]}}, sample_in,
                 {SAMPLE_SH{1'b0}}};
      end else if (cmd.next_x) begin
         x_in = y_ff;
      end
   end

   // Saturation flag gathers every section; the final clamp joins it in the output clip bit.
   always_comb begin
      flag_in = flag_ff;
      if (cmd.load_sample) begin
         flag_in = 1'b0;
      end else if ((cmd.take_y || cmd.take_z1 || cmd.take_z2) && rnd.sat) begin
         flag_in = 1'b1;
      end
   end

   // Final rounding to Q1.15 and clamp to full scale.
   always_comb begin
      x_rounded = {x_ff[DATA_W-1], x_ff} + (DATA_W+1)'(1 << (SAMPLE_SH - 1));
      y_wide    = x_rounded[DATA_W:SAMPLE_SH];
      clamp_hi  = !y_wide[DATA_W-SAMPLE_SH] && (|y_wide[DATA_W-SAMPLE_SH-1:SAMPLE_W-1]);
      clamp_lo  = y_wide[DATA_W-SAMPLE_SH] && !(&y_wide[DATA_W-SAMPLE_SH-1:SAMPLE_W-1]);
      if (clamp_hi) begin
         out_in = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (clamp_lo) begin
         out_in = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         out_in = y_wide[SAMPLE_W-1:0];
      end
      clip_in = flag_ff || clamp_hi || clamp_lo;
   end

   // Coefficient table and delay registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= ((i % TERMS) == 0) ? COEF_ONE : '0;
         end
         for (int i = 0; i < BANDS; i++) begin
            z1_ff[i] <= '0;
            z2_ff[i] <= '0;
         end
      end else begin
         if (cmd.write_coef && (32'(coef_index) < NUM_COEF)) begin
            coef_ff[COEF_AW'(coef_index)] <= coef_value;
         end
         if (cmd.clear_delay) begin
            for (int i = 0; i < BANDS; i++) begin
               z1_ff[i] <= '0;
               z2_ff[i] <= '0;
            end
         end else begin
            if (cmd.take_z1) begin
               z1_ff[cmd.band] <= rnd.value;
            end
            if (cmd.take_z2) begin
               z2_ff[cmd.band] <= rnd.value;
            end
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.take_y) begin
         y_ff <= rnd.value;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   assign sample_out = out_ff;
   assign clipped    = clip_ff;

endmodule

/* sv/bce_controller.sv */
// Controller: sequences the nine steps of each section and the channel handshakes.
module bce_controller
   import bce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bce_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Steps within one section.
   localparam logic [3:0] PH_MUL_A0  = 4'd0;
   localparam logic [3:0] PH_ADD_A0  = 4'd1;
   localparam logic [3:0] PH_TAKE_Y  = 4'd2;
   localparam logic [3:0] PH_ADD_A1  = 4'd3;
   localparam logic [3:0] PH_SUB_B1  = 4'd4;
   localparam logic [3:0] PH_TAKE_Z1 = 4'd5;
   localparam logic [3:0] PH_ADD_A2  = 4'd6;
   localparam logic [3:0] PH_SUB_B2  = 4'd7;
   localparam logic [3:0] PH_TAKE_Z2 = 4'd8;

   logic [1:0]        state_ff, state_in;
   logic [3:0]        phase_ff, phase_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              emit_ok;
   logic              last_band;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign last_band = (band_ff == BAND_W'(BANDS - 1));
   assign rsp_valid = rsp_valid_ff;

   // Command decode from state and step.
   always_comb begin
      cmd             = '0;
      cmd.band        = band_ff;
      cmd.acc_op      = ACC_HOLD;
      cmd.load_sample = accept && (req_mode == MODE_FILTER);
      cmd.write_coef  = accept && (req_mode == MODE_WRITE);
      cmd.clear_delay = accept && (req_mode == MODE_CLEAR);
      cmd.emit        = (state_ff == ST_FINISH) && emit_ok;
      if (state_ff == ST_RUN) begin
         case (phase_ff)
            PH_MUL_A0: begin
               cmd.mul_en = 1'b1;
               cmd.term   = TERM_A0;
               cmd.acc_op = ACC_LOAD_Z1;
            end
            PH_ADD_A0: begin
               cmd.acc_op = ACC_ADD;
            end
            PH_TAKE_Y: begin
               cmd.take_y = 1'b1;
               cmd.mul_en = 1'b1;
               cmd.term   = TERM_A1;
               cmd.acc_op = ACC_LOAD_Z2;
            end
            PH_ADD_A1: begin
               cmd.acc_op    = ACC_ADD;
               cmd.mul_en    = 1'b1;
               cmd.mul_use_y = 1'b1;
               cmd.term      = TERM_B1;
            end
            PH_SUB_B1: begin
               cmd.acc_op = ACC_SUB;
            end
            PH_TAKE_Z1: begin
               cmd.take_z1 = 1'b1;
               cmd.mul_en  = 1'b1;
               cmd.term    = TERM_A2;
               cmd.acc_op  = ACC_CLEAR;
            end
            PH_ADD_A2: begin
               cmd.acc_op    = ACC_ADD;
               cmd.mul_en    = 1'b1;
               cmd.mul_use_y = 1'b1;
               cmd.term      = TERM_B2;
            end
            PH_SUB_B2: begin
               cmd.acc_op = ACC_SUB;
            end
            PH_TAKE_Z2: begin
               cmd.take_z2 = 1'b1;
               cmd.next_x  = 1'b1;
            end
            default: begin
               cmd.acc_op = ACC_HOLD;
            end
         endcase
      end
   end

   // Next state, step and band.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      band_in  = band_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_sample) begin
               state_in = ST_RUN;
               phase_in = PH_MUL_A0;
               band_in  = '0;
            end
         end
         ST_RUN: begin
            if (phase_ff == PH_TAKE_Z2) begin
               phase_in = PH_MUL_A0;
               if (last_band) begin
                  state_in = ST_FINISH;
               end else begin
                  band_in = band_ff + BAND_W'(1);
               end
            end else begin
               phase_in = phase_ff + 4'd1;
            end
         end
         ST_FINISH: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result word valid: set when a word is written, cleared when it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_MUL_A0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/biquad_cascade_equalizer_unit.sv */
// Top level of the five-band biquad cascade equalizer.
// Each sample word gives one result word; the single shared multiplier runs nine steps
// per section in turn, and the result word is held until the receiver takes it.
// One sample is in work at a time, so no new word is accepted until its result is written.
// Coefficient-write and clear words give no result word.
// Synchronous reset loads a0 = 1.0 and zero for other terms, and zeroes all delay values.
module biquad_cascade_equalizer_unit
   import bce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   bce_req_if.sink  req_chan,
   bce_rsp_if.source rsp_chan
);

   bce_cmd_type cmd;

   // Sequencer.
   bce_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   bce_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_in  (req_chan.sample_in),
      .coef_index (req_chan.coef_index),
      .coef_value (req_chan.coef_value),
      .sample_out (rsp_chan.sample_out),
      .clipped    (rsp_chan.clipped)
   );

endmodule

/* tb/biquad_cascade_equalizer_unit_test.sv */
// Self-checking testbench for the biquad cascade equalizer with its own fixed-point predictor.
module biquad_cascade_equalizer_unit_test;
   import bce_pkg::*;

   // The one mode that the block ignores.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam longint Q23_MAX        = 64'sd2147483647;
   localparam longint Q23_MIN        = -64'sd2147483648;
   localparam longint Q20_ONE        = 64'sd1 <<< COEF_FRAC;
   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     SETTLE_CYCLES  = 100;
   localparam int     PHASE_WORDS    = 400;

   typedef struct {
      logic [MODE_W-1:0]          mode;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         index;
      logic signed [COEF_W-1:0]   coef;
   } eq_word_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
   } eq_result_type;

   logic clock;
   logic reset;

   bce_req_if req_chan ();
   bce_rsp_if rsp_chan ();

   biquad_cascade_equalizer_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: coefficient table and the z1/z2 pair of every band.
   logic signed [COEF_W-1:0] coef_table [NUM_COEF];
   logic signed [DATA_W-1:0] delay_line [2*BANDS];

   eq_word_type   pending_words [$];
   eq_result_type expected_outputs [$];
   eq_word_type   word_on_bus;

   int queued_count;
   int mismatches;
   int results_seen;
   int idle_cycles;
   int send_idle_pct;
   int stall_pct;

   int sender_idle_by_phase [4]    = '{0, 66, 0, 22};
   int receiver_stall_by_phase [4] = '{0, 0, 66, 22};

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Round a 43-fraction-bit sum half up to Q8.23 and saturate to 32 bits.
   function automatic logic signed [DATA_W-1:0] round_to_q23(input longint acc,
                                                             inout logic clip);
      longint r;
      r = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (r > Q23_MAX) begin
         clip = 1'b1;
         r    = Q23_MAX;
      end else if (r < Q23_MIN) begin
         clip = 1'b1;
         r    = Q23_MIN;
      end
      return r[DATA_W-1:0];
   endfunction

   // Apply one accepted word to the predictor and queue the result it causes.
   task automatic equalize_word(input eq_word_type w);
      longint                   x;
      longint                   y;
      longint                   c0, c1, c2, c3, c4;
      logic signed [DATA_W-1:0] stage_out;
      logic signed [DATA_W-1:0] z1_next;
      logic signed [DATA_W-1:0] z2_next;
      logic                     clip;
      eq_result_type            res;
      case (w.mode)
         MODE_WRITE: begin
            if (w.index < NUM_COEF) coef_table[w.index] = w.coef;
         end
         MODE_CLEAR: begin
            foreach (delay_line[i]) delay_line[i] = '0;
         end
         MODE_FILTER: begin
            clip = 1'b0;
            x    = longint'(w.sample) * (64'sd1 <<< SAMPLE_SH);
            for (int b = 0; b < BANDS; b++) begin
               c0 = longint'(coef_table[b*TERMS + int'(TERM_A0)]);
               c1 = longint'(coef_table[b*TERMS + int'(TERM_A1)]);
               c2 = longint'(coef_table[b*TERMS + int'(TERM_A2)]);
               c3 = longint'(coef_table[b*TERMS + int'(TERM_B1)]);
               c4 = longint'(coef_table[b*TERMS + int'(TERM_B2)]);
               stage_out = round_to_q23(x * c0 + longint'(delay_line[2*b]) * Q20_ONE, clip);
               z1_next   = round_to_q23(x * c1 + longint'(delay_line[2*b+1]) * Q20_ONE
                                        - c3 * longint'(stage_out), clip);
               z2_next   = round_to_q23(x * c2 - c4 * longint'(stage_out), clip);
               delay_line[2*b]   = z1_next;
               delay_line[2*b+1] = z2_next;
               x = longint'(stage_out);
            end
            y = (x + (64'sd1 <<< (SAMPLE_SH - 1))) >>> SAMPLE_SH;
            if (y > 64'sd32767) begin
               y    = 64'sd32767;
               clip = 1'b1;
            end else if (y < -64'sd32768) begin
               y    = -64'sd32768;
               clip = 1'b1;
            end
            res.sample_out = y[SAMPLE_W-1:0];
            res.clipped    = clip;
            expected_outputs.push_back(res);
         end
         default: ;
      endcase
   endtask

   // Every field random, so that unused fields toggle too.
   function automatic eq_word_type make_word(input logic [MODE_W-1:0] mode);
      eq_word_type w;
      w.mode   = mode;
      w.sample = SAMPLE_W'($urandom);
      w.index  = INDEX_W'($urandom);
      w.coef   = COEF_W'($urandom);
      return w;
   endfunction

   function automatic eq_word_type make_sample(input logic signed [SAMPLE_W-1:0] s);
      eq_word_type w;
      w        = make_word(MODE_FILTER);
      w.sample = s;
      return w;
   endfunction

   function automatic eq_word_type make_write(input logic [INDEX_W-1:0] idx,
                                              input logic signed [COEF_W-1:0] value);
      eq_word_type w;
      w       = make_word(MODE_WRITE);
      w.index = idx;
      w.coef  = value;
      return w;
   endfunction

   // Mostly stable sections: feed-forward terms within 1.5, feedback terms small.
   function automatic logic signed [COEF_W-1:0] draw_coef(input int idx);
      int term;
      term = idx % TERMS;
      if ($urandom_range(0, 7) == 0) return COEF_W'($urandom);
      if (term == int'(TERM_B1)) return COEF_W'(int'($urandom_range(0, 1048576)) - 524288);
      if (term == int'(TERM_B2)) return COEF_W'(int'($urandom_range(0, 838860)) - 419430);
      return COEF_W'(int'($urandom_range(0, 3145728)) - 1572864);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
         1, 2:    return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Ignored words are queued but not counted toward the stimulus size.
   task automatic queue_word(input eq_word_type w);
      pending_words.push_back(w);
      if (!(w.mode == MODE_UNUSED || (w.mode == MODE_WRITE && w.index >= NUM_COEF)))
         queued_count++;
   endtask

   // One session: a coefficient update, usually a clear, then a run of samples
   // with the odd stray word mixed in.
   task automatic queue_session();
      int idx;
      if ($urandom_range(0, 2) == 0) begin
         for (idx = 0; idx < NUM_COEF; idx++)
            queue_word(make_write(INDEX_W'(idx), draw_coef(idx)));
      end else begin
         repeat ($urandom_range(1, 5)) begin
            idx = $urandom_range(0, NUM_COEF - 1);
            queue_word(make_write(INDEX_W'(idx), draw_coef(idx)));
         end
      end
      if ($urandom_range(0, 3) != 0) queue_word(make_word(MODE_CLEAR));
      repeat ($urandom_range(20, 60)) begin
         if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 2))
               0:       queue_word(make_word(MODE_UNUSED));
               1:       queue_word(make_word(MODE_WRITE));
               default: queue_word(make_word(MODE_CLEAR));
            endcase
         end
         queue_word(make_sample(draw_sample()));
      end
   endtask

   task automatic queue_random_words(input int count);
      int goal;
      goal = queued_count + count;
      while (queued_count < goal) queue_session();
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("ERROR: result %0d: %s", results_seen, what);
   endtask

   // Driver: predicts each accepted word and presents the next pending one.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) equalize_word(word_on_bus);
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               word_on_bus         = pending_words.pop_front();
               req_chan.mode       <= word_on_bus.mode;
               req_chan.sample_in  <= word_on_bus.sample;
               req_chan.coef_index <= word_on_bus.index;
               req_chan.coef_value <= word_on_bus.coef;
               req_chan.valid      <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      eq_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_chan.sample_out !== want.sample_out)
                  report_mismatch($sformatf("sample_out %0d, expected %0d",
                                            rsp_chan.sample_out, want.sample_out));
               if (rsp_chan.clipped !== want.clipped)
                  report_mismatch($sformatf("clipped %b, expected %b",
                                            rsp_chan.clipped, want.clipped));
            end
            results_seen++;
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog counter: cycles since the last accepted word on either side.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("biquad_cascade_equalizer_unit: mismatch");
      $finish;
   end

   // Main sequence: directed words, then four idling phases of random sessions.
   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_FILTER;
      req_chan.sample_in  = '0;
      req_chan.coef_index = '0;
      req_chan.coef_value = '0;
      rsp_chan.ready      = 1'b0;
      idle_cycles         = 0;
      queued_count        = 0;
      mismatches          = 0;
      results_seen        = 0;
      send_idle_pct       = sender_idle_by_phase[0];
      stall_pct           = receiver_stall_by_phase[0];
      foreach (coef_table[i]) coef_table[i] = ((i % TERMS) == int'(TERM_A0)) ? COEF_ONE : '0;
      foreach (delay_line[i]) delay_line[i] = '0;

      // Unity cascade passes the extremes and zero straight through.
      queue_word(make_sample(16'sh0000));
      queue_word(make_sample(16'sh7fff));
      queue_word(make_sample(16'sh8000));
      queue_word(make_word(MODE_UNUSED));
      // A gain of two in the first band: half scale lands on full scale plus one.
      queue_word(make_write(INDEX_W'(0), 24'sh200000));
      queue_word(make_sample(16'sh4000));
      queue_word(make_sample(16'sh8000));
      queue_word(make_sample(16'sh3fff));
      // Extreme feedback terms in the last band.
      queue_word(make_write(INDEX_W'(NUM_COEF - 1), 24'sh800000));
      queue_word(make_write(INDEX_W'(NUM_COEF - 2), 24'sh7fffff));
      queue_word(make_sample(16'sd100));
      queue_word(make_sample(-16'sd1));
      queue_word(make_word(MODE_CLEAR));
      queue_word(make_sample(16'sd1));
      // Indexes past the table write nothing.
      queue_word(make_write(INDEX_W'(NUM_COEF), 24'sh7fffff));
      queue_word(make_write(5'd31, 24'sh800000));
      queue_word(make_sample(16'sd1234));
      // Maximum gain in every band after the first drives the internal values into saturation.
      for (int b = 1; b < BANDS; b++) queue_word(make_write(INDEX_W'(b * TERMS), 24'sh7fffff));
      queue_word(make_sample(16'sh7fff));
      queue_word(make_sample(16'sh8000));
      queue_word(make_word(MODE_CLEAR));
      queue_random_words(PHASE_WORDS);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         // The sender stays quiet between phases until every result has come.
         if (phase != 0) begin
            @(negedge clock);
            send_idle_pct = sender_idle_by_phase[phase];
            stall_pct     = receiver_stall_by_phase[phase];
            queue_random_words(PHASE_WORDS);
         end
         do @(negedge clock);
         while (pending_words.size() != 0 || req_chan.valid || expected_outputs.size() != 0);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("biquad_cascade_equalizer_unit: match");
      else
         $display("biquad_cascade_equalizer_unit: mismatch");
      $finish;
   end

endmodule
